### rtl/core/sdr_pkg.sv
// ---------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the segment deframer and reassembler.
// ---------------------------------------------------------------------------
package sdr_pkg;

    // Frame geometry
    localparam int FRAME_BYTES_DEFAULT = 1024;
    localparam int HDR_BYTES           = 6;

    // Queue depths between front, back and result ports
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Widths of the tracking state
    localparam int POS_W  = 17;
    localparam int CNT_W  = 25;
    localparam int ADDR_W = 25;
    localparam int CODE_W = 16;
    localparam int SIZE_W = 24;

    // Header byte positions within a frame
    localparam logic [POS_W-1:0] POS_CODE_HI = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CODE_LO = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SIZE_HI = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SIZE_MD = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SIZE_LO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SEGMENT = POS_W'(5);

    // Message status reported with each word
    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ABORT = 2'd2
    } status_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic              payload;
        logic              pre_drop;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [SIZE_W-1:0] held_size;
        status_t           status;
        logic [CODE_W-1:0] msg_code;
        logic [SIZE_W-1:0] msg_size;
    } item_t;

    // Finished result word
    typedef struct packed {
        logic              write_valid;
        logic [23:0]       write_address;
        logic [7:0]        write_byte;
        logic              write_dropped;
        status_t           status;
        logic [CODE_W-1:0] message_code;
        logic [SIZE_W-1:0] message_size;
    } result_t;

endpackage

### rtl/core/sdr_fifo.sv
// ---------------------------------------------------------------------------
// sdr_fifo
// Small synchronous queue of registers with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module sdr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sdr_pkg::MID_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold stored words until overwritten
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow occupancy");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop without push did not shrink occupancy");

endmodule

### rtl/core/sdr_front.sv
// ---------------------------------------------------------------------------
// sdr_front
// Header parser: tracks frame position, holds code and size of the message,
// works out the base address of each segment and classifies every byte.
// ---------------------------------------------------------------------------
module sdr_front #(
    parameter int FRAME_BYTES = sdr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          frame_end,
    output sdr_pkg::item_t item
);

    localparam int POS_W  = sdr_pkg::POS_W;
    localparam int CNT_W  = sdr_pkg::CNT_W;
    localparam int ADDR_W = sdr_pkg::ADDR_W;
    localparam int CODE_W = sdr_pkg::CODE_W;
    localparam int SIZE_W = sdr_pkg::SIZE_W;

    localparam logic [ADDR_W-1:0] ROOM      = ADDR_W'(FRAME_BYTES - sdr_pkg::HDR_BYTES);
    localparam logic [POS_W-1:0]  FRAME_LIM = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0]  POS_MAX   = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              have_hdr_reg, have_hdr_next;
    logic [7:0]        code_hi_reg, code_hi_next;
    logic              skip_reg, skip_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [15:0]       size_cap_reg, size_cap_next;
    logic              seg_zero_reg, seg_zero_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] base_prod;
    logic [CODE_W-1:0] rx_code;

    // Base address of the segment: (segment - 1) * payload room
    assign base_prod = ADDR_W'(data_byte - 8'd1) * ROOM;
    assign rx_code   = {code_hi_reg, data_byte};

    // Parse header bytes and classify payload
    always_comb
    begin
        pos_next      = pos_reg;
        have_hdr_next = have_hdr_reg;
        code_hi_next  = code_hi_reg;
        skip_next     = skip_reg;
        code_next     = code_reg;
        size_next     = size_reg;
        size_cap_next = size_cap_reg;
        seg_zero_next = seg_zero_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;

        item           = '0;
        item.data      = data_byte;
        item.addr      = addr_reg;
        item.held_size = size_reg;
        item.status    = sdr_pkg::ST_BUSY;

        if (!skip_reg)
        begin
            case (pos_reg)
                sdr_pkg::POS_CODE_HI:
                begin
                    code_hi_next = data_byte;
                end
                sdr_pkg::POS_CODE_LO:
                begin
                    if (!have_hdr_reg)
                    begin
                        code_next = rx_code;
                    end
                    else if (rx_code != code_reg)
                    begin
                        skip_next = 1'b1;
                    end
                end
                sdr_pkg::POS_SIZE_HI:
                begin
                    if (!have_hdr_reg)
                    begin
                        size_cap_next = {data_byte, 8'h00};
                    end
                end
                sdr_pkg::POS_SIZE_MD:
                begin
                    if (!have_hdr_reg)
                    begin
                        size_cap_next = {size_cap_reg[15:8], data_byte};
                    end
                end
                sdr_pkg::POS_SIZE_LO:
                begin
                    if (!have_hdr_reg)
                    begin
                        size_next     = {size_cap_reg, data_byte};
                        have_hdr_next = 1'b1;
                    end
                end
                sdr_pkg::POS_SEGMENT:
                begin
                    seg_zero_next = (data_byte == 8'd0);
                    addr_next     = base_prod;
                end
                default:
                begin
                    item.payload  = 1'b1;
                    item.pre_drop = seg_zero_reg || (pos_reg >= FRAME_LIM);
                    addr_next     = addr_reg + 1'b1;
                    if (count_reg != CNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            endcase
        end

        // Close the frame: abort on a short one, complete when size is met
        if (frame_end)
        begin
            if (pos_reg <= sdr_pkg::POS_SIZE_LO)
            begin
                item.status   = sdr_pkg::ST_ABORT;
                have_hdr_next = 1'b0;
                count_next    = '0;
            end
            else if (have_hdr_reg && (count_next >= CNT_W'(size_reg)))
            begin
                item.status   = sdr_pkg::ST_DONE;
                item.msg_code = code_reg;
                item.msg_size = size_reg;
                have_hdr_next = 1'b0;
                count_next    = '0;
            end
            pos_next  = '0;
            skip_next = 1'b0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            have_hdr_reg <= 1'b0;
            code_hi_reg  <= '0;
            skip_reg     <= 1'b0;
            code_reg     <= '0;
            size_reg     <= '0;
            size_cap_reg <= '0;
            seg_zero_reg <= 1'b0;
            count_reg    <= '0;
            addr_reg     <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            have_hdr_reg <= have_hdr_next;
            code_hi_reg  <= code_hi_next;
            skip_reg     <= skip_next;
            code_reg     <= code_next;
            size_reg     <= size_next;
            size_cap_reg <= size_cap_next;
            seg_zero_reg <= seg_zero_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
        end
    end

    a_skip_needs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> have_hdr_reg)
        else $error("frame skipped with no message header held");

    a_skip_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == sdr_pkg::POS_CODE_HI) |-> !skip_reg)
        else $error("skip flag survived into a new frame");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end && (pos_reg <= sdr_pkg::POS_SIZE_LO))
            |=> (count_reg == '0 && !have_hdr_reg))
        else $error("short frame did not clear message state");

endmodule

### rtl/core/sdr_back.sv
// ---------------------------------------------------------------------------
// sdr_back
// Placement stage: checks each payload word against the message size and
// forms the result word from a classified byte.
// ---------------------------------------------------------------------------
module sdr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  sdr_pkg::item_t  item,
    output sdr_pkg::result_t result
);

    logic in_message;
    logic placed;

    assign in_message = item.addr < sdr_pkg::ADDR_W'(item.held_size);
    assign placed     = item.payload && !item.pre_drop && in_message;

    // Form the result word; unplaced writes read as zero
    always_comb
    begin
        result               = '0;
        result.write_valid   = placed;
        result.write_dropped = item.payload && !placed;
        result.status        = item.status;
        result.message_code  = item.msg_code;
        result.message_size  = item.msg_size;
        if (placed)
        begin
            result.write_address = item.addr[23:0];
            result.write_byte    = item.data;
        end
    end

    a_valid_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !(result.write_valid && result.write_dropped))
        else $error("word both placed and dropped");

    a_done_not_payload_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.status != sdr_pkg::ST_DONE) |->
            (result.message_code == '0 && result.message_size == '0))
        else $error("message details shown without completion");

    a_header_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !item.payload) |-> (!result.write_valid && !result.write_dropped))
        else $error("header byte produced a write");

endmodule

### rtl/core/segment_deframer_reassembler_unit.sv
// ---------------------------------------------------------------------------
// segment_deframer_reassembler_unit
// Frame parser and message reassembler producing one result word per byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive data_byte and frame_end with push while
//   full is low; frame_end marks the last byte of each frame.
//   Result side is a queue: while empty is low the oldest result word is on
//   the result ports; pop takes it. Every accepted byte yields one word.
//   A byte's word is registered in the middle queue and then in the result
//   queue before it shows on the result ports.
//   Throughput is one byte per cycle while full is low; the parser handles
//   each header step and address increment per byte; the segment base multiply is
//   registered on the segment byte and used from the first payload byte.
//   A two-entry queue sits between parser and placement stage and another
//   ahead of the result ports, so each side may stall on its own.
//   When the receiver stops popping, the result queue fills, the placement
//   stage holds, the middle queue fills and full rises; nothing is lost.
//   Reset empties both queues and leaves no message in progress.
// ---------------------------------------------------------------------------
module segment_deframer_reassembler_unit #(
    parameter int FRAME_BYTES = sdr_pkg::FRAME_BYTES_DEFAULT,
    parameter int MID_DEPTH   = sdr_pkg::MID_DEPTH,
    parameter int OUT_DEPTH   = sdr_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        write_valid,
    output logic [23:0] write_address,
    output logic [7:0]  write_byte,
    output logic        write_dropped,
    output logic [1:0]  status,
    output logic [15:0] message_code,
    output logic [23:0] message_size
);

    localparam int ITEM_W   = $bits(sdr_pkg::item_t);
    localparam int RESULT_W = $bits(sdr_pkg::result_t);

    sdr_pkg::item_t   front_item;
    sdr_pkg::item_t   mid_item;
    sdr_pkg::result_t back_result;
    sdr_pkg::result_t out_result;
    logic [ITEM_W-1:0]   mid_rdata;
    logic [RESULT_W-1:0] out_rdata;
    logic in_accept;
    logic mid_empty;
    logic out_full;
    logic back_take;

    assign in_accept = push && !full;
    assign back_take = !mid_empty && !out_full;
    assign mid_item  = sdr_pkg::item_t'(mid_rdata);
    assign out_result = sdr_pkg::result_t'(out_rdata);

    // Parse and classify incoming bytes
    sdr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .item      (front_item)
    );

    // Decouple parser from placement
    sdr_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (back_take),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // Place payload and form result words
    sdr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (back_take),
        .item   (mid_item),
        .result (back_result)
    );

    // Hold result words for the receiver
    sdr_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_take),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign write_valid   = out_result.write_valid;
    assign write_address = out_result.write_address;
    assign write_byte    = out_result.write_byte;
    assign write_dropped = out_result.write_dropped;
    assign status        = out_result.status;
    assign message_code  = out_result.message_code;
    assign message_size  = out_result.message_size;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (back_take && out_full) |-> 1'b0)
        else $error("placement stage pushed into a full result queue");

    a_take_moves_word: assert property (@(posedge clk) disable iff (!rst_n)
        back_take |=> !empty)
        else $error("taken word did not reach the result queue");

    a_empty_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && mid_empty) |-> !back_take)
        else $error("word taken from an empty queue");

endmodule
